[sv/rfc_pkg.sv]
package rfc_pkg;

  // Largest accepted frame, checksum byte included
  localparam int unsigned MAX_FRAME_BYTES = 128;

  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [COUNT_W-1:0] MIN_BODY_BYTES = 9'd5;
  localparam logic [COUNT_W-1:0] MAX_BODY_BYTES = COUNT_W'(MAX_FRAME_BYTES);
  localparam logic [7:0] FRAME_HEAD = 8'h42;

  // Header offsets
  localparam logic [COUNT_W-1:0] OFS_HEADER  = 9'd0;
  localparam logic [COUNT_W-1:0] OFS_LENGTH  = 9'd1;
  localparam logic [COUNT_W-1:0] OFS_PORT    = 9'd2;
  localparam logic [COUNT_W-1:0] OFS_ADDRESS = 9'd3;
  localparam logic [COUNT_W-1:0] OFS_COMMAND = 9'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LONG     = 3'd2,
    ST_HEADER   = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_CHECKSUM = 3'd5,
    ST_ADDRESS  = 3'd6
  } status_t;

  // Result item as packed on the output tdata, lowest field last
  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] payload_len;
    logic [7:0] command;
    logic [7:0] port;
    logic       frame_ok;
    status_t    status;
  } result_t;

endpackage

[sv/radio_frame_checker.sv]
// Radio frame checker: takes one packet byte per cycle on the slave stream
// when ready (tlast on the checksum byte) and, for every tlast transaction,
// registers one verdict for the master stream. Frame layout: 0x42, length,
// port, address, command, payload, additive 8-bit checksum over all bytes
// before it. Status codes in priority order: too short (under five bytes
// before the checksum), too long (more than MAX_FRAME_BYTES in all), bad
// header, length mismatch, bad checksum, wrong address (node_address set
// through the cfg channel; the user must write it only while idle, the block
// does not enforce this). The byte rate is set by the running sum and header
// latches; a one-entry skid register behind the output register keeps input
// flowing while one verdict waits; input stalls only when two are held.
module radio_frame_checker
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // node_address
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // last_byte
  // verdict stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] status, [3] frame_ok, [11:4] port,
                                      // [19:12] command, [27:20] payload_len
);

  logic [7:0]         node_address;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;
  logic [7:0]         header_byte;
  logic [7:0]         length_byte;
  logic [7:0]         port_byte;
  logic [7:0]         address_byte;
  logic [7:0]         command_byte;

  logic    in_accept;
  logic    res_valid;
  status_t status_next;
  result_t res;

  result_t out_reg;
  logic    out_valid;
  result_t skid_reg;
  logic    skid_valid;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign res_valid     = in_accept && s_axis_tlast;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_address <= cfg_data;
    end
  end

  // Per-frame state: count, running sum, header latches
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_sum  <= '0;
      header_byte  <= '0;
      length_byte  <= '0;
      port_byte    <= '0;
      address_byte <= '0;
      command_byte <= '0;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        byte_count   <= '0;
        running_sum  <= '0;
        header_byte  <= '0;
        length_byte  <= '0;
        port_byte    <= '0;
        address_byte <= '0;
        command_byte <= '0;
      end else begin
        unique case (byte_count)
          OFS_HEADER:  header_byte  <= s_axis_tdata;
          OFS_LENGTH:  length_byte  <= s_axis_tdata;
          OFS_PORT:    port_byte    <= s_axis_tdata;
          OFS_ADDRESS: address_byte <= s_axis_tdata;
          OFS_COMMAND: command_byte <= s_axis_tdata;
          default: ;
        endcase
        running_sum <= running_sum + s_axis_tdata;
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

  // Verdict, first failing check wins
  always_comb begin
    priority if (byte_count < MIN_BODY_BYTES) begin
      status_next = ST_SHORT;
    end else if (byte_count >= MAX_BODY_BYTES) begin
      status_next = ST_LONG;
    end else if (header_byte != FRAME_HEAD) begin
      status_next = ST_HEADER;
    end else if ({1'b0, length_byte} != byte_count) begin
      status_next = ST_LENGTH;
    end else if (s_axis_tdata != running_sum) begin
      status_next = ST_CHECKSUM;
    end else if (address_byte != node_address) begin
      status_next = ST_ADDRESS;
    end else begin
      status_next = ST_OK;
    end

    res.pad         = '0;
    res.status      = status_next;
    res.frame_ok    = (status_next == ST_OK);
    res.port        = port_byte;
    res.command     = command_byte;
    res.payload_len = (status_next == ST_OK) ? (length_byte - MIN_BODY_BYTES[7:0]) : 8'd0;
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_axis_tready) begin
      if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_axis_tready) begin
      if (res_valid) begin
        skid_reg <= res;
      end
    end else if (skid_valid) begin
      out_reg <= skid_reg;
    end else if (res_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_reg;

`ifndef ASSERT_OFF
  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // frame state is cleared after the checksum byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast) |=> (byte_count == '0 && running_sum == '0))
    else $error("frame state not cleared after last byte");

  // frame_ok agrees with status
  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reg.frame_ok == (out_reg.status == ST_OK)))
    else $error("frame_ok disagrees with status");

  // payload length only reported for accepted frames
  a_len_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.frame_ok) |-> (out_reg.payload_len == 8'd0))
    else $error("payload length on rejected frame");
`endif

endmodule
